// ----- rtl/core/pdv_pkg.sv -----
// Package for the perspective divide / viewport block.
// Fixed-point widths, divider lane layout, pipeline word structs and helpers.
// No dependencies.
package pdv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int DIM_W     = 16;
    localparam int DIVD_W    = DATA_W + FRAC_BITS;
    localparam int REM_W     = DATA_W;
    localparam int QS_W      = DIVD_W + 1;
    localparam int T_W       = 35;
    localparam int PV_W      = T_W + DIM_W + 1;
    localparam int PT_W      = 2 * DATA_W;
    localparam int NUM_CELLS = DIVD_W;
    localparam int LANES     = 4;
    localparam int CFG_IDX_W = 8;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_N = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DIVD_W-1:0] dq;
    } lane_t;

    typedef struct packed {
        logic                     valid;
        lane_t [LANES-1:0]        lanes;
        logic [DATA_W-1:0]        divisor;
        logic [LANES-1:0]         neg;
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic                     wz;
    } cell_word_t;

    typedef struct packed {
        logic                     valid;
        logic signed [PV_W-1:0]   psx;
        logic signed [PV_W-1:0]   psy;
        logic signed [PT_W-1:0]   pu;
        logic signed [PT_W-1:0]   pv;
        logic signed [DATA_W-1:0] qz;
        logic signed [DATA_W-1:0] niw;
        logic                     wz;
    } post_word_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] val);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        begin
            hi = 66'sd2147483647;
            lo = -66'sd2147483648;
            if (val > hi) begin
                sat32 = hi[DATA_W-1:0];
            end else if (val < lo) begin
                sat32 = lo[DATA_W-1:0];
            end else begin
                sat32 = val[DATA_W-1:0];
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] val);
        mag32 = val[DATA_W-1] ? (~val + DATA_W'(1)) : val;
    endfunction

endpackage

// ----- rtl/core/pdv_cell.sv -----
// One restoring-division cell: one quotient bit for every lane per cycle while adv is high.
// Uses pdv_pkg for the word layout.
module pdv_cell
    import pdv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  cell_word_t word_in,
    output cell_word_t word_out
);

    cell_word_t word_reg;
    cell_word_t word_next;

    always_comb begin
        logic [REM_W:0] sh;
        logic [REM_W:0] trial;
        word_next = word_in;
        for (int i = 0; i < LANES; i++) begin
            sh    = {word_in.lanes[i].rem, word_in.lanes[i].dq[DIVD_W-1]};
            trial = sh - {1'b0, word_in.divisor};
            if (!trial[REM_W]) begin
                word_next.lanes[i].rem = trial[REM_W-1:0];
                word_next.lanes[i].dq  = {word_in.lanes[i].dq[DIVD_W-2:0], 1'b1};
            end else begin
                word_next.lanes[i].rem = sh[REM_W-1:0];
                word_next.lanes[i].dq  = {word_in.lanes[i].dq[DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (adv) begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

// ----- rtl/core/pdv_post.sv -----
// Post-divide stage: signs, clamps, viewport and texture products, registered.
// Uses pdv_pkg; fed by the last division cell.
module pdv_post
    import pdv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  cell_word_t       word_in,
    input  logic [DIM_W-1:0] vp_width,
    input  logic [DIM_W-1:0] vp_height,
    output post_word_t       post_out
);

    localparam logic signed [QS_W:0]  ONE_Q   = (QS_W+1)'(1) <<< FRAC_BITS;
    localparam logic signed [QS_W:0]  T_LIMIT = (QS_W+1)'(1) <<< (T_W - 2);

    post_word_t post_reg;
    post_word_t post_next;

    logic signed [QS_W-1:0] qs [LANES];
    logic signed [QS_W:0]   tx_full;
    logic signed [QS_W:0]   ty_full;
    logic signed [T_W-1:0]  tx;
    logic signed [T_W-1:0]  ty;
    logic signed [DIM_W:0]  wid_s;
    logic signed [DIM_W:0]  hgt_s;
    logic signed [DATA_W-1:0] niw_s;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            qs[i] = word_in.neg[i] ? -$signed({1'b0, word_in.lanes[i].dq})
                                   :  $signed({1'b0, word_in.lanes[i].dq});
        end
    end

    assign tx_full = (QS_W+1)'(qs[LANE_X]) + ONE_Q;
    assign ty_full = ONE_Q - (QS_W+1)'(qs[LANE_Y]);

    always_comb begin
        if (tx_full > T_LIMIT) begin
            tx = T_LIMIT[T_W-1:0];
        end else if (tx_full < -T_LIMIT) begin
            tx = -T_LIMIT[T_W-1:0];
        end else begin
            tx = tx_full[T_W-1:0];
        end
        if (ty_full > T_LIMIT) begin
            ty = T_LIMIT[T_W-1:0];
        end else if (ty_full < -T_LIMIT) begin
            ty = -T_LIMIT[T_W-1:0];
        end else begin
            ty = ty_full[T_W-1:0];
        end
    end

    assign wid_s = $signed({1'b0, vp_width});
    assign hgt_s = $signed({1'b0, vp_height});
    assign niw_s = sat32(66'(qs[LANE_N]));

    always_comb begin
        post_next.valid = word_in.valid;
        post_next.psx   = PV_W'(tx) * PV_W'(wid_s);
        post_next.psy   = PV_W'(ty) * PV_W'(hgt_s);
        post_next.pu    = PT_W'(word_in.u) * PT_W'(niw_s);
        post_next.pv    = PT_W'(word_in.v) * PT_W'(niw_s);
        post_next.qz    = sat32(66'(qs[LANE_Z]));
        post_next.niw   = niw_s;
        post_next.wz    = word_in.wz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_reg.valid <= 1'b0;
        end else if (adv) begin
            post_reg <= post_next;
        end
    end

    assign post_out = post_reg;

endmodule

// ----- rtl/core/perspective_divide_viewport.sv -----
// Perspective divide and viewport transform, top level.
// From the accepting edge a vertex passes the input register, 48 division cells, product stage, output register.
// Throughput one vertex per cycle; the whole pipe holds while the output word is stalled.
// The 48-cell divider chain makes up most of the latency. Synchronous active-low reset clears
// valid bits and sets the viewport width to 640 and height to 480.
module perspective_divide_viewport
    import pdv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]         cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_clip_x,
    input  logic signed [DATA_W-1:0] s_clip_y,
    input  logic signed [DATA_W-1:0] s_clip_z,
    input  logic signed [DATA_W-1:0] s_clip_w,
    input  logic signed [DATA_W-1:0] s_tex_u,
    input  logic signed [DATA_W-1:0] s_tex_v,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_screen_x,
    output logic signed [DATA_W-1:0] m_screen_y,
    output logic signed [DATA_W-1:0] m_depth_z,
    output logic signed [DATA_W-1:0] m_neg_inv_w,
    output logic signed [DATA_W-1:0] m_u_scaled,
    output logic signed [DATA_W-1:0] m_v_scaled,
    output logic                     m_w_zero
);

    localparam logic [DIVD_W-1:0] NIW_DIVIDEND = DIVD_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [PT_W:0] ROUND_T = (PT_W+1)'((1 << FRAC_BITS) - 1);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             adv;

    cell_word_t in_reg;
    cell_word_t in_next;
    cell_word_t chain [NUM_CELLS+1];
    post_word_t post;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] sx_reg, sy_reg, dz_reg, niw_reg, us_reg, vs_reg;
    logic                     wz_reg;
    logic signed [DATA_W-1:0] sx_next, sy_next, us_next, vs_next;
    logic signed [PV_W:0]     hx, hy;
    logic signed [PT_W:0]     tu, tv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SCREEN_WIDTH) begin
                width_reg <= cfg_data;
            end
            if (cfg_index == REG_SCREEN_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        in_next.valid   = s_valid;
        in_next.divisor = mag32(s_clip_w);
        in_next.lanes[LANE_X].dq = {mag32(s_clip_x), FRAC_BITS'(0)};
        in_next.lanes[LANE_Y].dq = {mag32(s_clip_y), FRAC_BITS'(0)};
        in_next.lanes[LANE_Z].dq = {mag32(s_clip_z), FRAC_BITS'(0)};
        in_next.lanes[LANE_N].dq = NIW_DIVIDEND;
        for (int i = 0; i < LANES; i++) begin
            in_next.lanes[i].rem = '0;
        end
        in_next.neg[LANE_X] = s_clip_x[DATA_W-1] ^ s_clip_w[DATA_W-1];
        in_next.neg[LANE_Y] = s_clip_y[DATA_W-1] ^ s_clip_w[DATA_W-1];
        in_next.neg[LANE_Z] = s_clip_z[DATA_W-1] ^ s_clip_w[DATA_W-1];
        in_next.neg[LANE_N] = !s_clip_w[DATA_W-1];
        in_next.u  = s_tex_u;
        in_next.v  = s_tex_v;
        in_next.wz = (s_clip_w == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (adv) begin
            in_reg <= in_next;
        end
    end

    assign chain[0] = in_reg;

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        pdv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .word_in  (chain[c]),
            .word_out (chain[c+1])
        );
    end

    pdv_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .word_in   (chain[NUM_CELLS]),
        .vp_width  (width_reg),
        .vp_height (height_reg),
        .post_out  (post)
    );

    assign hx = (PV_W+1)'(post.psx) + (PV_W+1)'(post.psx[PV_W-1]);
    assign hy = (PV_W+1)'(post.psy) + (PV_W+1)'(post.psy[PV_W-1]);
    assign tu = (PT_W+1)'(post.pu) + (post.pu[PT_W-1] ? ROUND_T : '0);
    assign tv = (PT_W+1)'(post.pv) + (post.pv[PT_W-1] ? ROUND_T : '0);

    assign sx_next = sat32(66'(hx >>> 1));
    assign sy_next = sat32(66'(hy >>> 1));
    assign us_next = sat32(66'(tu >>> FRAC_BITS));
    assign vs_next = sat32(66'(tv >>> FRAC_BITS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= post.valid;
            sx_reg  <= post.wz ? '0 : sx_next;
            sy_reg  <= post.wz ? '0 : sy_next;
            dz_reg  <= post.wz ? '0 : post.qz;
            niw_reg <= post.wz ? '0 : post.niw;
            us_reg  <= post.wz ? '0 : us_next;
            vs_reg  <= post.wz ? '0 : vs_next;
            wz_reg  <= post.wz;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_screen_x  = sx_reg;
    assign m_screen_y  = sy_reg;
    assign m_depth_z   = dz_reg;
    assign m_neg_inv_w = niw_reg;
    assign m_u_scaled  = us_reg;
    assign m_v_scaled  = vs_reg;
    assign m_w_zero    = wz_reg;

`ifndef NO_ASSERTIONS
    a_wzero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_w_zero) |-> (m_screen_x == 0 && m_screen_y == 0 && m_depth_z == 0 &&
            m_neg_inv_w == 0 && m_u_scaled == 0 && m_v_scaled == 0))
        else $error("w_zero word carries nonzero fields");
    a_niw_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_w_zero) |-> (m_neg_inv_w != 0))
        else $error("neg_inv_w is zero for nonzero w");
    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (post.valid == $past(post.valid) &&
            chain[NUM_CELLS].valid == $past(chain[NUM_CELLS].valid)))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ----- bench/tb.sv -----
// Testbench for perspective_divide_viewport: directed table then random vertices,
// checked against a behavioral predictor. Depends on pdv_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb;
    import pdv_pkg::*;

    localparam int RAND_VERTS = 1880;
    localparam int PIPE_LAT   = 51;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        logic signed [31:0] x, y, z, w, u, v;
    } vert_t;

    typedef struct {
        logic signed [31:0] sx, sy, dz, niw, us, vs;
        logic               wz;
    } pix_t;

    typedef struct {
        vert_t vin;
        logic  known;
        pix_t  res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_clip_x = '0, s_clip_y = '0, s_clip_z = '0;
    logic signed [31:0] s_clip_w = '0, s_tex_u = '0, s_tex_v = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_screen_x, m_screen_y, m_depth_z, m_neg_inv_w;
    logic signed [31:0] m_u_scaled, m_v_scaled;
    logic m_w_zero;

    logic [15:0] vp_width = 16'd640;
    logic [15:0] vp_height = 16'd480;
    pix_t pending_pix[$];
    int errors = 0;
    int words_out = 0;
    int words_in = 0;
    int cycles = 0;

    perspective_divide_viewport i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sat_q(longint val);
        if (val > 64'sd2147483647) return 64'sd2147483647;
        if (val < -64'sd2147483648) return -64'sd2147483648;
        return val;
    endfunction

    function automatic longint clamp40(longint val);
        longint g;
        g = 64'sd1 << 40;
        if (val > g) return g;
        if (val < -g) return -g;
        return val;
    endfunction

    function automatic pix_t project_vertex(vert_t vi);
        pix_t p;
        longint one, w, qx, qy, qz, niw;
        one = 64'sd65536;
        w = vi.w;
        p = '{default: '0};
        if (w == 0) begin
            p.wz = 1'b1;
            return p;
        end
        qx = clamp40((longint'(vi.x) * one) / w);
        qy = clamp40((longint'(vi.y) * one) / w);
        qz = (longint'(vi.z) * one) / w;
        niw = sat_q(-(one * one) / w);
        p.sx = 32'(sat_q((longint'({1'b0, vp_width}) * (qx + one)) / 2));
        p.sy = 32'(sat_q((longint'({1'b0, vp_height}) * (one - qy)) / 2));
        p.dz = 32'(sat_q(qz));
        p.niw = 32'(niw);
        p.us = 32'(sat_q((longint'(vi.u) * niw) / one));
        p.vs = 32'(sat_q((longint'(vi.v) * niw) / one));
        p.wz = 1'b0;
        return p;
    endfunction

    // valid stays up into the next word when there is no gap
    task automatic send_vertex(vert_t vi);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_clip_x <= vi.x; s_clip_y <= vi.y; s_clip_z <= vi.z;
        s_clip_w <= vi.w; s_tex_u <= vi.u; s_tex_v <= vi.v;
        do @(posedge aclk); while (!s_ready);
        words_in++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCREEN_WIDTH) vp_width = val;
        else if (idx == REG_SCREEN_HEIGHT) vp_height = val;
        @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_pix.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    // output stall pattern, with bursts of no stalls
    initial begin
        int hold;
        int burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (burst > 0) begin
                    burst--;
                    hold = 0;
                end else begin
                    hold = $urandom_range(0, 14);
                    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 60);
                end
                if (hold != 0) begin
                    m_ready <= 1'b0;
                    repeat (hold) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end else if (!m_ready && aresetn) begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        pix_t e;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (pending_pix.size() == 0) begin
                $error("unexpected output word");
                errors++;
            end else begin
                e = pending_pix.pop_front();
                if (m_screen_x !== e.sx) begin
                    $error("screen_x exp %0d got %0d", e.sx, m_screen_x); errors++;
                end
                if (m_screen_y !== e.sy) begin
                    $error("screen_y exp %0d got %0d", e.sy, m_screen_y); errors++;
                end
                if (m_depth_z !== e.dz) begin
                    $error("depth_z exp %0d got %0d", e.dz, m_depth_z); errors++;
                end
                if (m_neg_inv_w !== e.niw) begin
                    $error("neg_inv_w exp %0d got %0d", e.niw, m_neg_inv_w); errors++;
                end
                if (m_u_scaled !== e.us) begin
                    $error("u_scaled exp %0d got %0d", e.us, m_u_scaled); errors++;
                end
                if (m_v_scaled !== e.vs) begin
                    $error("v_scaled exp %0d got %0d", e.vs, m_v_scaled); errors++;
                end
                if (m_w_zero !== e.wz) begin
                    $error("w_zero exp %0b got %0b", e.wz, m_w_zero); errors++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_w();
        case ($urandom_range(0, 7))
            0: return 32'sd0;
            1: return $urandom;
            2: return $signed($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $signed($urandom_range(32'h0000_4000, 32'h0010_0000))
                            * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    initial begin
        row_t tbl[$];
        pix_t zr;
        vert_t vi;
        logic [15:0] dims[6][2];
        zr = '{default: '0};
        zr.wz = 1'b1;
        // zero w, extremes, unit w, tiny w, w of minus one, max negative values
        tbl.push_back('{'{32'sh10000, 32'sh10000, 32'sh10000, 0, 5, 5}, 1'b1, zr});
        tbl.push_back('{'{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0,
                          32'sh80000000, 32'sh7fffffff}, 1'b1, zr});
        tbl.push_back('{'{0, 0, 0, 32'sh10000, 0, 0}, 1'b1,
                        '{32'sd640 << 15, 32'sd480 << 15, 0, -32'sh10000, 0, 0, 1'b0}});
        tbl.push_back('{'{32'sh10000, -32'sh10000, 32'sh8000, 32'sh10000,
                          32'sh10000, -32'sh10000}, 1'b0, zr});
        tbl.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1,
                          32'sh7fffffff, 32'sh80000000}, 1'b0, zr});
        tbl.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000, -1,
                          32'sh80000000, 32'sh7fffffff}, 1'b0, zr});
        tbl.push_back('{'{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh80000000}, 1'b0, zr});
        tbl.push_back('{'{32'sh7fffffff, 32'sh80000000, 1, 32'sh7fffffff,
                          32'sh7fffffff, -1}, 1'b0, zr});
        tbl.push_back('{'{-1, 1, -1, -32'sh10000, -1, 1}, 1'b0, zr});
        tbl.push_back('{'{32'sh30000, -32'sh20000, 32'sh5555, 32'sh20000,
                          32'sh18000, -32'sh4000}, 1'b0, zr});
        tbl.push_back('{'{32'sh12345678, -32'sh12345678, 32'sh1, 32'sh100,
                          32'sh1000, 32'sh2000}, 1'b0, zr});
        tbl.push_back('{'{-32'sh30000, 32'sh20000, 0, -32'sh28000, 7, -7}, 1'b0, zr});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (tbl[i]) begin
            pending_pix.push_back(tbl[i].known ? tbl[i].res : project_vertex(tbl[i].vin));
            send_vertex(tbl[i].vin);
        end
        drain();

        // extremes of the viewport registers, then a zero size and a stray index
        dims = '{'{16'd1, 16'd1}, '{16'hffff, 16'hffff}, '{16'd1, 16'hffff},
                 '{16'd1920, 16'd1080}, '{16'd0, 16'd0}, '{16'h8001, 16'd2}};
        foreach (dims[p]) begin
            write_reg(REG_SCREEN_WIDTH, dims[p][0]);
            write_reg(REG_SCREEN_HEIGHT, dims[p][1]);
            if (p == 5) write_reg(CFG_IDX_W'(2 + $urandom_range(0, 200)), 16'($urandom));
            for (int k = 0; k < 8; k++) begin
                vi = '{rand_q(), rand_q(), rand_q(), rand_w(), rand_q(), rand_q()};
                pending_pix.push_back(project_vertex(vi));
                send_vertex(vi);
            end
            drain();
        end

        for (int k = 0; k < RAND_VERTS; k++) begin
            if (k % 400 == 0) begin
                drain();
                write_reg(REG_SCREEN_WIDTH, 16'($urandom_range(1, 16'hffff)));
                write_reg(REG_SCREEN_HEIGHT, 16'($urandom_range(1, 16'hffff)));
            end
            vi = '{rand_q(), rand_q(), rand_q(), rand_w(), rand_q(), rand_q()};
            pending_pix.push_back(project_vertex(vi));
            send_vertex(vi);
        end
        drain();

        $display("Run covered %0d vertices in, %0d words out, over several viewport sizes.",
                 words_in, words_out);
        if (errors == 0 && pending_pix.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
